// ===== rtl/core/sensor_offset_calibrator_macros.svh =====
// ----------------------------------------------------------------------------
// Sensor offset calibrator assertion macros
// Shared concurrent check forms used by the calibrator top level.
// ----------------------------------------------------------------------------
`ifndef SENSOR_OFFSET_CALIBRATOR_MACROS_SVH
`define SENSOR_OFFSET_CALIBRATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define SOC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("soc check failed");

// next-cycle implication, disabled during reset
`define SOC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("soc check failed");

`endif

// ===== rtl/core/soc_pkg.sv =====
// ----------------------------------------------------------------------------
// Sensor offset calibrator package
// Shared codes, register indexes and lane control types.
// ----------------------------------------------------------------------------
package soc_pkg;

   localparam int SMP_W      = 16;
   localparam int CFG_CNT_W  = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // request codes
   localparam logic REQ_START  = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   // result status codes
   localparam logic [1:0] ST_WRITE = 2'd0;
   localparam logic [1:0] ST_DONE  = 2'd1;
   localparam logic [1:0] ST_FAIL  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MODE        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_COUNT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_NEXT_COUNT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_ROUNDS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_Z_TARGET    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TOLERANCE   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_INIT_DIV    = 3'd6;

   localparam logic MODE_GYRO = 1'b1;

   typedef struct packed {
      logic       clear;
      logic       accum;
      logic       div_mean;
      logic       div_init;
      logic       apply;
      logic       mode;
      logic [7:0] tolerance;
      logic [4:0] idiv;
   } soc_lane_ctrl_type;

   typedef struct packed {
      logic        busy;
      logic        ready;
      logic [15:0] offset;
   } soc_lane_stat_type;

   typedef struct packed {
      logic busy;
      logic all_ready;
   } soc_merge_type;

endpackage

// ===== rtl/core/soc_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel interface
// Start or three-axis sample words with valid/ready handshake.
// ----------------------------------------------------------------------------
interface soc_req_if;
   logic                                valid;
   logic                                ready;
   logic                                req_type;
   logic signed [soc_pkg::SMP_W-1:0]    sample_x;
   logic signed [soc_pkg::SMP_W-1:0]    sample_y;
   logic signed [soc_pkg::SMP_W-1:0]    sample_z;

   modport source (output valid, req_type, sample_x, sample_y, sample_z, input ready);
   modport sink   (input valid, req_type, sample_x, sample_y, sample_z, output ready);
endinterface

// ===== rtl/core/soc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel interface
// Status and offset words with valid/ready handshake.
// ----------------------------------------------------------------------------
interface soc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          status;
   logic signed [soc_pkg::SMP_W-1:0]    offset_x;
   logic signed [soc_pkg::SMP_W-1:0]    offset_y;
   logic signed [soc_pkg::SMP_W-1:0]    offset_z;

   modport source (output valid, status, offset_x, offset_y, offset_z, input ready);
   modport sink   (input valid, status, offset_x, offset_y, offset_z, output ready);
endinterface

// ===== rtl/core/soc_csr_if.sv =====
// ----------------------------------------------------------------------------
// Configuration write interface
// Register index and write data with valid/ready handshake.
// ----------------------------------------------------------------------------
interface soc_csr_if;
   logic                               valid;
   logic                               ready;
   logic [soc_pkg::CSR_IDX_W-1:0]      index;
   logic [soc_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/soc_div.sv =====
// ----------------------------------------------------------------------------
// Sequential signed divider
// Restoring division, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module soc_div #(
   parameter int DVD_W = 27,
   parameter int DVS_W = 11
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0]        divisor,
   output logic                    busy,
   output logic                    done,
   output logic signed [DVD_W-1:0] quotient
);
   localparam int CNT_W = $clog2(DVD_W);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(DVD_W - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic             neg_ff, neg_in;
   logic [DVS_W:0]   shifted;
   logic [DVS_W:0]   diff;
   logic             ge;
   logic [DVD_W-1:0] mag;

   assign shifted = {rem_ff, quo_ff[DVD_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign ge      = shifted >= {1'b0, dvs_ff};
   assign mag     = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = mag;
         rem_in  = '0;
         dvs_in  = divisor;
         neg_in  = dividend[DVD_W-1];
      end else if (busy_ff) begin
         quo_in = {quo_ff[DVD_W-2:0], ge};
         rem_in = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule

// ===== rtl/core/soc_lane.sv =====
// ----------------------------------------------------------------------------
// Calibrator axis lane
// Per-axis sample sum, batch mean, offset and readiness for one axis.
// ----------------------------------------------------------------------------
module soc_lane #(
   parameter int COUNT_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  soc_pkg::soc_lane_ctrl_type          ctrl,
   input  logic [COUNT_BITS:0]                 batch_len,
   input  logic signed [soc_pkg::SMP_W-1:0]    target,
   input  logic signed [soc_pkg::SMP_W-1:0]    sample,
   output soc_pkg::soc_lane_stat_type          stat
);
   import soc_pkg::*;

   localparam int SUM_W = SMP_W + COUNT_BITS + 1;
   localparam int LEN_W = COUNT_BITS + 1;
   localparam int ERR_W = SUM_W + 1;

   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic signed [SUM_W-1:0] mean_ff, mean_in;
   logic [15:0]             offset_ff, offset_in;
   logic                    ready_ff, ready_in;
   logic                    init_ff, init_in;

   logic signed [SUM_W-1:0] dvd;
   logic [LEN_W-1:0]        dvs;
   logic                    div_busy, div_done;
   logic signed [SUM_W-1:0] quo;

   logic signed [ERR_W-1:0] err, err_adj, diff, step;
   logic [ERR_W-1:0]        mag;
   logic                    in_tol;
   logic [15:0]             moved;

   // error against target, and its one-eighth step toward zero
   // the mean keeps the full sum width: a batch cut short by a lowered count
   // can average more samples than its length
   assign err     = ERR_W'(mean_ff) - ERR_W'(target);
   assign diff    = ERR_W'(target) - ERR_W'(mean_ff);
   assign mag     = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
   assign in_tol  = mag <= ERR_W'(ctrl.tolerance);
   assign err_adj = err + (err[ERR_W-1] ? ERR_W'(7) : ERR_W'(0));
   assign step    = err_adj >>> 3;
   assign moved   = offset_ff - step[15:0];

   assign dvd = ctrl.div_init ? SUM_W'(diff) : sum_ff;
   assign dvs = ctrl.div_init ? LEN_W'(ctrl.idiv) : batch_len;

   soc_div #(
      .DVD_W (SUM_W),
      .DVS_W (LEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.div_mean | ctrl.div_init),
      .dividend (dvd),
      .divisor  (dvs),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (quo)
   );

   always_comb begin
      sum_in    = sum_ff;
      mean_in   = mean_ff;
      offset_in = offset_ff;
      ready_in  = ready_ff;
      init_in   = init_ff;
      if (ctrl.clear) begin
         sum_in    = '0;
         mean_in   = '0;
         offset_in = '0;
         ready_in  = 1'b0;
      end else begin
         if (ctrl.accum) begin
            sum_in = sum_ff + SUM_W'(sample);
         end
         if (ctrl.div_mean) begin
            sum_in  = '0;
            init_in = 1'b0;
         end
         if (ctrl.div_init) begin
            init_in = 1'b1;
         end
         if (div_done) begin
            if (init_ff) begin
               offset_in = quo[15:0];
            end else begin
               mean_in = quo;
            end
         end
         if (ctrl.apply) begin
            if (ctrl.mode == MODE_GYRO) begin
               // a ready gyro axis is frozen
               if (!in_tol && !ready_ff) begin
                  offset_in = moved;
               end else begin
                  ready_in = 1'b1;
               end
            end else begin
               if (!in_tol) begin
                  offset_in = moved;
               end
               ready_in = in_tol;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff    <= '0;
         mean_ff   <= '0;
         offset_ff <= '0;
         ready_ff  <= 1'b0;
         init_ff   <= 1'b0;
      end else begin
         sum_ff    <= sum_in;
         mean_ff   <= mean_in;
         offset_ff <= offset_in;
         ready_ff  <= ready_in;
         init_ff   <= init_in;
      end
   end

   assign stat.busy   = div_busy | div_done;
   assign stat.ready  = ready_ff;
   assign stat.offset = offset_ff;

endmodule

// ===== rtl/core/soc_merge.sv =====
// ----------------------------------------------------------------------------
// Calibrator lane merge
// Combines the three axis lanes into shared busy and all-ready flags.
// ----------------------------------------------------------------------------
module soc_merge (
   input  soc_pkg::soc_lane_stat_type lane_x,
   input  soc_pkg::soc_lane_stat_type lane_y,
   input  soc_pkg::soc_lane_stat_type lane_z,
   output soc_pkg::soc_merge_type     merged
);
   import soc_pkg::*;

   logic [2:0] ready_vec;
   logic [1:0] nready;

   assign ready_vec = {lane_z.ready, lane_y.ready, lane_x.ready};
   assign nready    = 2'(ready_vec[0]) + 2'(ready_vec[1]) + 2'(ready_vec[2]);

   assign merged.busy      = lane_x.busy | lane_y.busy | lane_z.busy;
   assign merged.all_ready = (ready_vec == 3'b111) && (nready == 2'd3);

endmodule

// ===== rtl/core/sensor_offset_calibrator.sv =====
// ----------------------------------------------------------------------------
// Sensor offset calibrator
// Three-axis iterative offset calibration sequencer with one lane per axis.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries a start word (req_type 0) or a three-axis sample word.
//   rsp_bus returns offsets to write (status write), or the final offsets
//   with status done or failed. csr_bus writes the seven setup registers
//   and is always ready; write it only while no run is in flight.
//   A start word is answered with zero offsets. A sample that does
//   not close a batch gives no word. A sample that closes the first
//   batch makes two passes through each lane's one-bit-per-cycle
//   divider, for the mean and for the initial offset. A sample that
//   closes a correction batch makes one divider pass.
//   All three lanes divide in lockstep.
//   Reset clears the run to idle and loads register defaults; samples
//   arriving while idle are dropped. The response sits in an output
//   register: req_bus.ready is low whenever that register holds a word
//   that is not taken in the same cycle, so a stalled receiver holds off
//   every request word until the output drains.
// ----------------------------------------------------------------------------
`include "sensor_offset_calibrator_macros.svh"

module sensor_offset_calibrator #(
   parameter int COUNT_BITS = 10
) (
   input  logic      clock,
   input  logic      reset,
   soc_req_if.sink   req_bus,
   soc_rsp_if.source rsp_bus,
   soc_csr_if.sink   csr_bus
);
   import soc_pkg::*;

   localparam int LEN_W = COUNT_BITS + 1;
   localparam int CMP_W = (LEN_W > CFG_CNT_W) ? LEN_W : CFG_CNT_W;

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_FIRST = 2'd1;
   localparam logic [1:0] PH_ROUND = 2'd2;

   localparam logic [2:0] SQ_ACCEPT    = 3'd0;
   localparam logic [2:0] SQ_MEAN_GO   = 3'd1;
   localparam logic [2:0] SQ_MEAN_WAIT = 3'd2;
   localparam logic [2:0] SQ_INIT_GO   = 3'd3;
   localparam logic [2:0] SQ_INIT_WAIT = 3'd4;
   localparam logic [2:0] SQ_APPLY     = 3'd5;
   localparam logic [2:0] SQ_DECIDE    = 3'd6;

   // setup registers
   logic                 mode_ff;
   logic [CFG_CNT_W-1:0] first_cnt_ff;
   logic [CFG_CNT_W-1:0] next_cnt_ff;
   logic [5:0]           max_rounds_ff;
   logic signed [15:0]   z_target_ff;
   logic [7:0]           tolerance_ff;
   logic [4:0]           idiv_ff;

   logic [2:0]            seq_ff, seq_in;
   logic [1:0]            phase_ff, phase_in;
   logic [COUNT_BITS-1:0] smp_cnt_ff, smp_cnt_in;
   logic [5:0]            round_ff, round_in;
   logic [LEN_W-1:0]      len_ff, len_in;

   logic                  out_valid_ff, out_valid_in;
   logic [1:0]            out_status_ff, out_status_in;
   logic [15:0]           out_x_ff, out_x_in;
   logic [15:0]           out_y_ff, out_y_in;
   logic [15:0]           out_z_ff, out_z_in;

   logic                  req_accept;
   logic                  running;
   logic [CFG_CNT_W-1:0]  count_sel;
   logic [CMP_W-1:0]      count_ext, lim_ext, len_ext;
   logic                  batch_end;

   soc_lane_ctrl_type     lane_ctrl;
   soc_lane_stat_type     stat_x, stat_y, stat_z;
   soc_merge_type         merged;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= 1'b0;
         first_cnt_ff  <= CFG_CNT_W'(200);
         next_cnt_ff   <= CFG_CNT_W'(100);
         max_rounds_ff <= 6'd35;
         z_target_ff   <= 16'sd16384;
         tolerance_ff  <= 8'd8;
         idiv_ff       <= 5'd8;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            REG_MODE:        mode_ff       <= csr_bus.data[0];
            REG_FIRST_COUNT: first_cnt_ff  <= csr_bus.data[CFG_CNT_W-1:0];
            REG_NEXT_COUNT:  next_cnt_ff   <= csr_bus.data[CFG_CNT_W-1:0];
            REG_MAX_ROUNDS:  max_rounds_ff <= csr_bus.data[5:0];
            REG_Z_TARGET:    z_target_ff   <= csr_bus.data;
            REG_TOLERANCE:   tolerance_ff  <= csr_bus.data[7:0];
            REG_INIT_DIV:    idiv_ff       <= csr_bus.data[4:0];
            default: ;
         endcase
      end
   end

   // batch length: zero means one, clamped to the counter range
   assign running   = (phase_ff == PH_FIRST) || (phase_ff == PH_ROUND);
   assign count_sel = (phase_ff == PH_FIRST) ? first_cnt_ff : next_cnt_ff;
   assign count_ext = CMP_W'(count_sel);
   assign lim_ext   = CMP_W'(1) << COUNT_BITS;
   assign len_ext   = (count_sel == '0) ? CMP_W'(1) :
                      ((count_ext > lim_ext) ? lim_ext : count_ext);
   assign batch_end = !((CMP_W'(smp_cnt_ff) + CMP_W'(1)) < len_ext);

   assign req_bus.ready = (seq_ff == SQ_ACCEPT) && (!out_valid_ff || rsp_bus.ready);
   assign req_accept    = req_bus.valid && req_bus.ready;

   always_comb begin
      seq_in        = seq_ff;
      phase_in      = phase_ff;
      smp_cnt_in    = smp_cnt_ff;
      round_in      = round_ff;
      len_in        = len_ff;
      out_valid_in  = rsp_bus.ready ? 1'b0 : out_valid_ff;
      out_status_in = out_status_ff;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_z_in      = out_z_ff;

      lane_ctrl           = '0;
      lane_ctrl.mode      = mode_ff;
      lane_ctrl.tolerance = tolerance_ff;
      lane_ctrl.idiv      = (idiv_ff == '0) ? 5'd1 : idiv_ff;

      case (seq_ff)
         SQ_ACCEPT: begin
            if (req_accept) begin
               if (req_bus.req_type == REQ_START) begin
                  lane_ctrl.clear = 1'b1;
                  phase_in        = PH_FIRST;
                  smp_cnt_in      = '0;
                  round_in        = '0;
                  out_valid_in    = 1'b1;
                  out_status_in   = ST_WRITE;
                  out_x_in        = '0;
                  out_y_in        = '0;
                  out_z_in        = '0;
               end else if (running) begin
                  lane_ctrl.accum = 1'b1;
                  if (batch_end) begin
                     smp_cnt_in = '0;
                     len_in     = len_ext[LEN_W-1:0];
                     seq_in     = SQ_MEAN_GO;
                  end else begin
                     smp_cnt_in = smp_cnt_ff + 1'b1;
                  end
               end
            end
         end
         SQ_MEAN_GO: begin
            lane_ctrl.div_mean = 1'b1;
            seq_in             = SQ_MEAN_WAIT;
         end
         SQ_MEAN_WAIT: begin
            if (!merged.busy) begin
               seq_in = (phase_ff == PH_FIRST) ? SQ_INIT_GO : SQ_APPLY;
            end
         end
         SQ_INIT_GO: begin
            lane_ctrl.div_init = 1'b1;
            seq_in             = SQ_INIT_WAIT;
         end
         SQ_INIT_WAIT: begin
            if (!merged.busy) begin
               seq_in = SQ_DECIDE;
            end
         end
         SQ_APPLY: begin
            lane_ctrl.apply = 1'b1;
            seq_in          = SQ_DECIDE;
         end
         SQ_DECIDE: begin
            seq_in        = SQ_ACCEPT;
            out_valid_in  = 1'b1;
            out_status_in = ST_WRITE;
            out_x_in      = stat_x.offset;
            out_y_in      = stat_y.offset;
            out_z_in      = stat_z.offset;
            if (phase_ff == PH_FIRST) begin
               phase_in = PH_ROUND;
               round_in = 6'd1;
               if (max_rounds_ff == '0) begin
                  phase_in      = PH_IDLE;
                  out_status_in = ST_FAIL;
               end
            end else if (merged.all_ready) begin
               phase_in      = PH_IDLE;
               out_status_in = ST_DONE;
            end else if (({1'b0, round_ff} + 7'd1) > {1'b0, max_rounds_ff}) begin
               phase_in      = PH_IDLE;
               out_status_in = ST_FAIL;
            end else begin
               round_in = round_ff + 1'b1;
            end
         end
         default: begin
            seq_in = SQ_ACCEPT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SQ_ACCEPT;
         phase_ff     <= PH_IDLE;
         smp_cnt_ff   <= '0;
         round_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         phase_ff     <= phase_in;
         smp_cnt_ff   <= smp_cnt_in;
         round_ff     <= round_in;
         out_valid_ff <= out_valid_in;
      end
      len_ff        <= len_in;
      out_status_ff <= out_status_in;
      out_x_ff      <= out_x_in;
      out_y_ff      <= out_y_in;
      out_z_ff      <= out_z_in;
   end

   soc_lane #(.COUNT_BITS(COUNT_BITS)) u_lane_x (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (lane_ctrl),
      .batch_len (len_ff),
      .target    (16'sd0),
      .sample    (req_bus.sample_x),
      .stat      (stat_x)
   );

   soc_lane #(.COUNT_BITS(COUNT_BITS)) u_lane_y (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (lane_ctrl),
      .batch_len (len_ff),
      .target    (16'sd0),
      .sample    (req_bus.sample_y),
      .stat      (stat_y)
   );

   soc_lane #(.COUNT_BITS(COUNT_BITS)) u_lane_z (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (lane_ctrl),
      .batch_len (len_ff),
      .target    (z_target_ff),
      .sample    (req_bus.sample_z),
      .stat      (stat_z)
   );

   soc_merge u_merge (
      .lane_x (stat_x),
      .lane_y (stat_y),
      .lane_z (stat_z),
      .merged (merged)
   );

   assign rsp_bus.valid    = out_valid_ff;
   assign rsp_bus.status   = out_status_ff;
   assign rsp_bus.offset_x = out_x_ff;
   assign rsp_bus.offset_y = out_y_ff;
   assign rsp_bus.offset_z = out_z_ff;

   // no word taken while the lane dividers run
   `SOC_ASSERT_NOW(a_no_accept_busy, clock, reset, req_accept, !merged.busy)
   // the decision cycle always leaves a word in the output register
   `SOC_ASSERT_NEXT(a_decide_loads, clock, reset, seq_ff == SQ_DECIDE, rsp_bus.valid)
   // a done word only when every axis lane is ready
   `SOC_ASSERT_NOW(a_done_ready, clock, reset,
      rsp_bus.valid && (rsp_bus.status == ST_DONE), merged.all_ready)

endmodule

// ===== test/sensor_offset_calibrator_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sensor offset calibrator checker
// Watches the request, response and setup channels, runs its own model of
// the calibration sequencer on every accepted word and compares each
// response word against the oldest predicted one.
// ----------------------------------------------------------------------------
module sensor_offset_calibrator_checker #(
   parameter int COUNT_BITS = 10
) (
   input  logic clock,
   input  logic reset,
   soc_req_if   req_bus,
   soc_rsp_if   rsp_bus,
   soc_csr_if   csr_bus,
   output int   fail_count,
   output int   words_pending
);
   import soc_pkg::*;

   typedef enum logic [1:0] {
      CAL_IDLE  = 2'd0,
      CAL_FIRST = 2'd1,
      CAL_ROUND = 2'd2
   } cal_phase_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [2:0][15:0] offset;
   } offset_word_type;

   // setup registers as last written
   logic                   cfg_mode;
   logic [9:0]             cfg_first;
   logic [9:0]             cfg_next;
   logic [5:0]             cfg_max_rounds;
   logic signed [15:0]     cfg_z_target;
   logic [7:0]             cfg_tol;
   logic [4:0]             cfg_idiv;

   // calibration run state
   cal_phase_type          run_phase;
   logic [COUNT_BITS-1:0]  sample_cnt;
   logic [5:0]             round_cnt;
   logic signed [26:0]     axis_sum [3];
   logic signed [15:0]     axis_off [3];
   logic                   axis_ok  [3];

   offset_word_type        expected_offsets [$];
   int                     mismatches;

   function automatic int batch_size(input logic [9:0] count);
      if (count == 0) return 1;
      if (int'(count) > (1 << COUNT_BITS)) return 1 << COUNT_BITS;
      return int'(count);
   endfunction

   task automatic push_offsets(input logic [1:0] status);
      offset_word_type w;
      w.status = status;
      for (int k = 0; k < 3; k++) w.offset[k] = axis_off[k];
      expected_offsets.push_back(w);
   endtask

   // one accepted request word through the sequencer
   task automatic calibrate_step(input logic kind, input logic signed [15:0] sx,
                                 input logic signed [15:0] sy,
                                 input logic signed [15:0] sz);
      logic signed [15:0] smp [3];
      int tgt [3];
      int mean [3];
      int len, div, err, mag, nready;
      logic in_tol;
      smp[0] = sx;
      smp[1] = sy;
      smp[2] = sz;
      if (kind == REQ_START) begin
         run_phase  = CAL_FIRST;
         sample_cnt = '0;
         round_cnt  = '0;
         for (int k = 0; k < 3; k++) begin
            axis_sum[k] = '0;
            axis_off[k] = '0;
            axis_ok[k]  = 1'b0;
         end
         push_offsets(ST_WRITE);
         return;
      end
      if (run_phase != CAL_FIRST && run_phase != CAL_ROUND) return;

      for (int k = 0; k < 3; k++) axis_sum[k] = axis_sum[k] + smp[k];
      len = batch_size(run_phase == CAL_FIRST ? cfg_first : cfg_next);
      if (int'(sample_cnt) + 1 < len) begin
         sample_cnt = sample_cnt + 1'b1;
         return;
      end

      tgt[0] = 0;
      tgt[1] = 0;
      tgt[2] = cfg_z_target;
      for (int k = 0; k < 3; k++) begin
         mean[k]     = int'(axis_sum[k]) / len;
         axis_sum[k] = '0;
      end
      sample_cnt = '0;

      if (run_phase == CAL_FIRST) begin
         div = (cfg_idiv == 0) ? 1 : int'(cfg_idiv);
         for (int k = 0; k < 3; k++) axis_off[k] = 16'((tgt[k] - mean[k]) / div);
         run_phase = CAL_ROUND;
         round_cnt = 6'd1;
         if (round_cnt > cfg_max_rounds) begin
            run_phase = CAL_IDLE;
            push_offsets(ST_FAIL);
         end else begin
            push_offsets(ST_WRITE);
         end
         return;
      end

      nready = 0;
      for (int k = 0; k < 3; k++) begin
         err    = mean[k] - tgt[k];
         mag    = (err < 0) ? -err : err;
         in_tol = (mag <= int'(cfg_tol));
         if (cfg_mode == MODE_GYRO) begin
            // gyro: a ready axis stays ready and is never moved again
            if (!in_tol && !axis_ok[k]) axis_off[k] = 16'(int'(axis_off[k]) - err / 8);
            else axis_ok[k] = 1'b1;
         end else begin
            if (!in_tol) axis_off[k] = 16'(int'(axis_off[k]) - err / 8);
            axis_ok[k] = in_tol;
         end
         if (axis_ok[k]) nready++;
      end

      if (nready == 3) begin
         run_phase = CAL_IDLE;
         push_offsets(ST_DONE);
      end else if (int'(round_cnt) + 1 > int'(cfg_max_rounds)) begin
         run_phase = CAL_IDLE;
         push_offsets(ST_FAIL);
      end else begin
         round_cnt = round_cnt + 1'b1;
         push_offsets(ST_WRITE);
      end
   endtask

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s expected %h actual %h", $realtime, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      offset_word_type w;
      if (reset) begin
         cfg_mode       = ~MODE_GYRO;
         cfg_first      = 10'd200;
         cfg_next       = 10'd100;
         cfg_max_rounds = 6'd35;
         cfg_z_target   = 16'sd16384;
         cfg_tol        = 8'd8;
         cfg_idiv       = 5'd8;
         run_phase      = CAL_IDLE;
         sample_cnt     = '0;
         round_cnt      = '0;
         for (int k = 0; k < 3; k++) begin
            axis_sum[k] = '0;
            axis_off[k] = '0;
            axis_ok[k]  = 1'b0;
         end
         expected_offsets.delete();
         mismatches = 0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               REG_MODE:        cfg_mode       = csr_bus.data[0];
               REG_FIRST_COUNT: cfg_first      = csr_bus.data[9:0];
               REG_NEXT_COUNT:  cfg_next       = csr_bus.data[9:0];
               REG_MAX_ROUNDS:  cfg_max_rounds = csr_bus.data[5:0];
               REG_Z_TARGET:    cfg_z_target   = csr_bus.data;
               REG_TOLERANCE:   cfg_tol        = csr_bus.data[7:0];
               REG_INIT_DIV:    cfg_idiv       = csr_bus.data[4:0];
               default: ;
            endcase
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_offsets.size() == 0) begin
               mismatches++;
               $display("%0t: word expected none actual status %0d offsets %h %h %h",
                        $realtime, rsp_bus.status, rsp_bus.offset_x, rsp_bus.offset_y,
                        rsp_bus.offset_z);
            end else begin
               w = expected_offsets.pop_front();
               compare_field("status", 16'(w.status), 16'(rsp_bus.status));
               compare_field("offset_x", w.offset[0], rsp_bus.offset_x);
               compare_field("offset_y", w.offset[1], rsp_bus.offset_y);
               compare_field("offset_z", w.offset[2], rsp_bus.offset_z);
            end
         end
         if (req_bus.valid && req_bus.ready)
            calibrate_step(req_bus.req_type, req_bus.sample_x, req_bus.sample_y,
                           req_bus.sample_z);
      end
      fail_count    <= mismatches + expected_offsets.size();
      words_pending <= expected_offsets.size();
   end

endmodule

// ===== test/sensor_offset_calibrator_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sensor offset calibrator testbench
// Drives setup writes, start words and sample batches with random gaps and
// response stalls, including one long response hold, and reports the
// verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module sensor_offset_calibrator_test;
   import soc_pkg::*;

   localparam int ITEM_TARGET   = 1600;
   localparam int IDLE_LIMIT    = 5000;
   localparam int SETTLE_CYCLES = 80;
   localparam int HOLD_CYCLES   = 400;

   typedef struct {
      logic               mode;
      logic [9:0]         first_count;
      logic [9:0]         next_count;
      logic [5:0]         max_rounds;
      logic signed [15:0] z_target;
      logic [7:0]         tolerance;
      logic [4:0]         init_div;
   } cal_setup_t;

   logic       clock = 1'b0;
   logic       reset;
   int         fail_count;
   int         words_pending;
   int         quiet_cycles = 0;
   int         gap_max;
   int         stall_max;
   int         hold_cycles;
   int         items_sent;
   cal_setup_t setup;

   soc_req_if req_bus ();
   soc_rsp_if rsp_bus ();
   soc_csr_if csr_bus ();

   always #5 clock = ~clock;

   sensor_offset_calibrator dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   sensor_offset_calibrator_checker offset_check (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .csr_bus       (csr_bus),
      .fail_count    (fail_count),
      .words_pending (words_pending)
   );

   function automatic logic signed [15:0] clamp16(input int v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return 16'(v);
   endfunction

   function automatic int batch_len(input logic [9:0] count);
      return (count == 0) ? 1 : int'(count);
   endfunction

   function automatic logic [9:0] pick_count();
      case ($urandom_range(0, 9))
         0:       return 10'd0;
         1:       return 10'($urandom_range(7, 40));
         default: return 10'($urandom_range(1, 6));
      endcase
   endfunction

   task automatic send_word(input logic kind, input logic signed [15:0] x,
                            input logic signed [15:0] y, input logic signed [15:0] z);
      int gap;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= kind;
      req_bus.sample_x <= x;
      req_bus.sample_y <= y;
      req_bus.sample_z <= z;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   task automatic send_start();
      send_word(REQ_START, 16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_setup(input cal_setup_t s);
      setup = s;
      write_reg(REG_MODE, 16'(s.mode));
      write_reg(REG_FIRST_COUNT, 16'(s.first_count));
      write_reg(REG_NEXT_COUNT, 16'(s.next_count));
      write_reg(REG_MAX_ROUNDS, 16'(s.max_rounds));
      write_reg(REG_Z_TARGET, s.z_target);
      write_reg(REG_TOLERANCE, 16'(s.tolerance));
      write_reg(REG_INIT_DIV, 16'(s.init_div));
   endtask

   // all words answered, then let any trailing sample finish
   task automatic wait_quiet();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (words_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one batch around a per-axis center; settle keeps every mean within tolerance
   task automatic send_batch(input int count, input bit settle);
      int center [3];
      int tgt, tol, noise, jx, jy, jz;
      logic signed [15:0] raw;
      tol   = int'(setup.tolerance);
      noise = settle ? 0 : int'($urandom_range(0, 2));
      for (int k = 0; k < 3; k++) begin
         tgt = (k == 2) ? int'(setup.z_target) : 0;
         raw = 16'($urandom);
         case (settle ? 0 : $urandom_range(0, 3))
            0, 1: center[k] = tgt + int'($urandom_range(0, 2 * tol)) - tol;
            2: center[k] = tgt + (raw[0] ? -1 : 1) * (tol + 1 + int'($urandom_range(0, 3000)));
            default: center[k] = raw;
         endcase
      end
      repeat (count) begin
         jx = int'($urandom_range(0, 2 * noise)) - noise;
         jy = int'($urandom_range(0, 2 * noise)) - noise;
         jz = int'($urandom_range(0, 2 * noise)) - noise;
         send_word(REQ_SAMPLE, clamp16(center[0] + jx), clamp16(center[1] + jy),
                   clamp16(center[2] + jz));
      end
   endtask

   task automatic run_calibration(input int rounds);
      send_start();
      // cut short: the next start restarts the run mid batch
      if ($urandom_range(0, 7) == 0) begin
         send_batch($urandom_range(0, batch_len(setup.first_count) - 1), 1'b0);
         return;
      end
      send_batch(batch_len(setup.first_count), 1'b0);
      for (int r = 1; r <= rounds; r++)
         send_batch(batch_len(setup.next_count), r == rounds);
      // strays after the run, mostly dropped while idle
      if ($urandom_range(0, 7) == 0) send_batch($urandom_range(1, 3), 1'b0);
   endtask

   // watchdog: no word moved on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("sensor_offset_calibrator: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // response side: random stalls, plus a long hold when asked
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         stall = $urandom_range(0, stall_max);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   initial begin
      cal_setup_t s;
      int phase_no;
      int runs;
      int rounds;
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.req_type <= REQ_START;
      req_bus.sample_x <= '0;
      req_bus.sample_y <= '0;
      req_bus.sample_z <= '0;
      csr_bus.valid    <= 1'b0;
      csr_bus.index    <= REG_MODE;
      csr_bus.data     <= '0;
      gap_max     = 16;
      stall_max   = 16;
      hold_cycles = 0;
      items_sent  = 0;
      phase_no    = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // accel run: idle sample, restart, done, then failure after max rounds
      s = '{mode: ~MODE_GYRO, first_count: 10'd1, next_count: 10'd2, max_rounds: 6'd3,
            z_target: 16'sd16384, tolerance: 8'd8, init_div: 5'd1};
      load_setup(s);
      send_word(REQ_SAMPLE, 16'sd1, 16'sd2, 16'sd3);
      send_word(REQ_START, 16'sh7fff, 16'sh8000, 16'sh5555);
      send_word(REQ_SAMPLE, 16'sh7fff, 16'sh8000, 16'sh8000);
      send_word(REQ_START, 16'sd0, 16'sd0, 16'sd0);
      send_word(REQ_SAMPLE, 16'sd0, 16'sd0, 16'sd16384);
      send_word(REQ_SAMPLE, 16'sd0, 16'sd0, 16'sd16384);
      send_word(REQ_SAMPLE, 16'sd4, -16'sd4, 16'sd16392);
      send_word(REQ_START, 16'shaaaa, 16'sh5555, 16'shffff);
      send_word(REQ_SAMPLE, 16'sd100, -16'sd100, 16'sd0);
      repeat (6) send_word(REQ_SAMPLE, 16'sd1000, -16'sd1000, 16'sd0);
      wait_quiet();

      // zero counts, zero divisor, zero max rounds
      s = '{mode: MODE_GYRO, first_count: 10'd0, next_count: 10'd0, max_rounds: 6'd0,
            z_target: 16'sh8000, tolerance: 8'd0, init_div: 5'd0};
      load_setup(s);
      send_word(REQ_START, 16'sd0, 16'sd0, 16'sd0);
      send_word(REQ_SAMPLE, -16'sd5, 16'sd7, 16'sh8000);
      wait_quiet();

      // gyro sticky ready, count lowered mid batch
      s = '{mode: MODE_GYRO, first_count: 10'd1, next_count: 10'd5, max_rounds: 6'd63,
            z_target: 16'sh7fff, tolerance: 8'd255, init_div: 5'd16};
      load_setup(s);
      send_word(REQ_START, 16'sd0, 16'sd0, 16'sd0);
      send_word(REQ_SAMPLE, 16'sd0, 16'sd0, 16'sh7fff);
      send_word(REQ_SAMPLE, 16'sd600, 16'sd0, 16'sh7fff);
      send_word(REQ_SAMPLE, 16'sd600, 16'sd0, 16'sh7fff);
      wait_quiet();
      write_reg(REG_NEXT_COUNT, 16'd1);
      setup.next_count = 10'd1;
      send_word(REQ_SAMPLE, 16'sd0, 16'sd0, 16'sh7fff);
      send_word(REQ_SAMPLE, 16'sd3, 16'sd0, 16'sh7fff);
      wait_quiet();

      while (items_sent < ITEM_TARGET) begin
         phase_no++;
         s.mode        = ($urandom_range(0, 1) != 0) ? MODE_GYRO : ~MODE_GYRO;
         s.first_count = pick_count();
         s.next_count  = pick_count();
         if (phase_no == 1) s.next_count = 10'd1023;
         if (phase_no == 3) s.first_count = 10'd1023;
         case ($urandom_range(0, 7))
            0:       s.max_rounds = 6'd63;
            1:       s.max_rounds = 6'($urandom_range(0, 63));
            default: s.max_rounds = 6'($urandom_range(1, 6));
         endcase
         case ($urandom_range(0, 5))
            0:       s.z_target = 16'sh8000;
            1:       s.z_target = 16'sh7fff;
            2:       s.z_target = 16'sd0;
            3:       s.z_target = 16'sd16384;
            default: s.z_target = 16'($urandom);
         endcase
         case ($urandom_range(0, 4))
            0:       s.tolerance = 8'd0;
            1:       s.tolerance = 8'd255;
            2:       s.tolerance = 8'($urandom);
            default: s.tolerance = 8'($urandom_range(1, 40));
         endcase
         s.init_div = 5'($urandom_range(0, 31));
         load_setup(s);
         gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 16;
         stall_max = ($urandom_range(0, 3) == 0) ? 0 : 16;

         if (phase_no == 2) begin
            // back-to-back starts against a held response fill the block
            gap_max     = 0;
            hold_cycles = HOLD_CYCLES;
            repeat (8) send_start();
         end

         runs = (phase_no == 3) ? 1 : $urandom_range(3, 6);
         repeat (runs) begin
            rounds = (phase_no == 1) ? 0 : $urandom_range(1, 6);
            run_calibration(rounds);
         end
         wait_quiet();
      end

      wait_quiet();
      if (fail_count == 0) begin
         $display("sensor_offset_calibrator: match");
      end else begin
         $display("sensor_offset_calibrator: mismatch");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/soc_pkg.sv
rtl/core/soc_req_if.sv
rtl/core/soc_rsp_if.sv
rtl/core/soc_csr_if.sv
rtl/core/soc_div.sv
rtl/core/soc_lane.sv
rtl/core/soc_merge.sv
rtl/core/sensor_offset_calibrator.sv
test/sensor_offset_calibrator_checker.sv
test/sensor_offset_calibrator_test.sv
